>>> hdl/vss_pkg.sv
// Shared widths, codes, reset values and the segment table of the voltmeter display scanner.
package vss_pkg;

    localparam int CMD_W      = 1;
    localparam int CODE_W     = 10;
    localparam int SCALE_W    = 12;
    localparam int POINT_W    = 2;
    localparam int SEG_W      = 8;
    localparam int SEL_W      = 3;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 3;
    localparam int POS_W      = 2;
    localparam int VAL_W      = 10;
    localparam int PROD_W     = CODE_W + SCALE_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SCALE_W;

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT = 1'b1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 12'd1000;
    localparam logic [POINT_W-1:0] POINT_RESET = 2'd1;

    localparam logic [VAL_W-1:0] MAX_SHOWN = 10'd999;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] t_digits;

    function automatic logic [SEG_W-2:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
        case (digit)
            4'd0:    return 7'h3F;
            4'd1:    return 7'h06;
            4'd2:    return 7'h5B;
            4'd3:    return 7'h4F;
            4'd4:    return 7'h66;
            4'd5:    return 7'h6D;
            4'd6:    return 7'h7D;
            4'd7:    return 7'h07;
            4'd8:    return 7'h7F;
            4'd9:    return 7'h6F;
            default: return 7'h00;
        endcase
    endfunction

endpackage

>>> hdl/vss_in_if.sv
// Input channel carrying sample and refresh tick items.
interface vss_in_if
    import vss_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [CODE_W-1:0]   adc_code;

    modport source (output valid, cmd, adc_code, input ready);
    modport sink   (input valid, cmd, adc_code, output ready);
endinterface

>>> hdl/vss_out_if.sv
// Output channel carrying segment and digit enable patterns.
interface vss_out_if
    import vss_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SEG_W-1:0]    segment_lines;
    logic [SEL_W-1:0]    digit_select_n;

    modport source (output valid, segment_lines, digit_select_n, input ready);
    modport sink   (input valid, segment_lines, digit_select_n, output ready);
endinterface

>>> hdl/vss_digit_split.sv
// Splits a value of 0 to 999 into hundreds, tens and units digits.
module vss_digit_split
    import vss_pkg::*;
(
    input  logic [VAL_W-1:0] i_value,
    output t_digits          o_digits
);

    localparam int H_PROD_W = 16;
    localparam int REM_W    = 7;
    localparam int T_PROD_W = 15;

    localparam logic [H_PROD_W-1:0] DIV100_MUL = 16'd41;
    localparam logic [T_PROD_W-1:0] DIV10_MUL  = 15'd205;
    localparam logic [VAL_W-1:0]    HUNDRED    = 10'd100;
    localparam logic [REM_W-1:0]    TEN        = 7'd10;

    logic [H_PROD_W-1:0] w_h_prod;
    logic [DIGIT_W-1:0]  w_hundreds;
    logic [REM_W-1:0]    w_rem;
    logic [T_PROD_W-1:0] w_t_prod;
    logic [DIGIT_W-1:0]  w_tens;
    logic [DIGIT_W-1:0]  w_units;

    // Reciprocal multiplies are exact over the range 0 to 999.
    assign w_h_prod   = H_PROD_W'(i_value) * DIV100_MUL;
    assign w_hundreds = w_h_prod[H_PROD_W-1 -: DIGIT_W];
    assign w_rem      = REM_W'(i_value - VAL_W'(w_hundreds) * HUNDRED);
    assign w_t_prod   = T_PROD_W'(w_rem) * DIV10_MUL;
    assign w_tens     = w_t_prod[T_PROD_W-1 -: DIGIT_W];
    assign w_units    = DIGIT_W'(w_rem - REM_W'(w_tens) * TEN);

    assign o_digits[0] = w_hundreds;
    assign o_digits[1] = w_tens;
    assign o_digits[2] = w_units;

endmodule

>>> hdl/voltmeter_seven_segment_scan_unit.sv
// Top level of the three-digit voltmeter seven-segment scanner.
//
// Items arrive on i_in with valid/ready; a transfer with cmd sample scales adc_code to
// tenths of a volt, floor(code * scale / (2^ADC_BITS - 1)), saturated to 999, and stores
// its three digits. A transfer with cmd tick produces one result on o_out: the pattern
// of the current digit with the decimal point on the configured position, and the
// active-low digit enables. The scan position then wraps over the three digits.
// Samples produce no result.
// Pipeline: product register, quotient register, then the digit store and the output
// register. One item is taken every cycle while i_in.ready is high, and the multiplier
// plus the constant division set the stage depth. Reset empties the pipeline, clears
// the digits and scan position, and loads scale 1000 and decimal point position 1.
// Configuration writes on i_cfg_* are to be made only while idle; the block itself does
// not enforce this. When o_out stalls, the output register holds its result; samples
// keep draining, and up to two further items are taken before i_in.ready drops.
module voltmeter_seven_segment_scan_unit
    import vss_pkg::*;
#(
    parameter int ADC_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    vss_in_if.sink                i_in,
    vss_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [PROD_W-1:0] FULL_SCALE = PROD_W'((1 << ADC_BITS) - 1);
    localparam int NUM_TERMS = PROD_W / ADC_BITS;
    localparam int MAX_CORR  = NUM_TERMS + 1;
    localparam int CORR_W    = $clog2(MAX_CORR + 1);
    localparam int Q_W       = PROD_W - ADC_BITS + 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_DIGITS - 1);

    logic [SCALE_W-1:0] r_scale;
    logic [POINT_W-1:0] r_point;

    logic               r_p_valid;
    logic [CMD_W-1:0]   r_p_cmd;
    logic [PROD_W-1:0]  r_p;

    logic               r_v_valid;
    logic [CMD_W-1:0]   r_v_cmd;
    logic [VAL_W-1:0]   r_v;

    t_digits            r_digits;
    logic [POS_W-1:0]   r_scan;

    logic               r_o_valid;
    logic [SEG_W-1:0]   r_o_seg;
    logic [SEL_W-1:0]   r_o_sel;

    logic               w_o_free;
    logic               w_v_go;
    logic               w_v_free;
    logic               w_p_free;
    logic               w_accept;

    logic [PROD_W-1:0]  w_q0;
    logic [PROD_W-1:0]  w_fs_mult;
    logic [PROD_W-1:0]  w_rem;
    logic [CORR_W-1:0]  w_corr;
    logic [Q_W-1:0]     w_q;
    logic [VAL_W-1:0]   w_val;

    t_digits            w_split;
    logic [POS_W-1:0]   w_pos;
    logic [DIGIT_W-1:0] w_digit;
    logic [SEG_W-1:0]   w_seg;
    logic [SEL_W-1:0]   w_sel;
    logic [POS_W-1:0]   w_next_scan;

    assign w_o_free = !r_o_valid || o_out.ready;
    assign w_v_go   = r_v_valid && ((r_v_cmd == CMD_SAMPLE) || w_o_free);
    assign w_v_free = !r_v_valid || w_v_go;
    assign w_p_free = !r_p_valid || w_v_free;
    assign w_accept = i_in.valid && w_p_free;

    assign i_in.ready           = w_p_free;
    assign o_out.valid          = r_o_valid;
    assign o_out.segment_lines  = r_o_seg;
    assign o_out.digit_select_n = r_o_sel;

    // Division by 2^N - 1 as a sum of shifted copies, then a small remainder correction.
    always_comb begin
        w_q0 = '0;
        for (int k = 1; k <= NUM_TERMS; k++) begin
            w_q0 = w_q0 + (r_p >> (k * ADC_BITS));
        end
    end

    assign w_fs_mult = (w_q0 << ADC_BITS) - w_q0;
    assign w_rem     = r_p - w_fs_mult;

    always_comb begin
        w_corr = '0;
        for (int j = 1; j <= MAX_CORR; j++) begin
            if (w_rem >= PROD_W'(j) * FULL_SCALE) begin
                w_corr = w_corr + CORR_W'(1);
            end
        end
    end

    assign w_q   = w_q0[Q_W-1:0] + Q_W'(w_corr);
    assign w_val = (PROD_W'(w_q) > PROD_W'(MAX_SHOWN)) ? MAX_SHOWN : VAL_W'(w_q);

    vss_digit_split u_digit_split (
        .i_value  (r_v),
        .o_digits (w_split)
    );

    assign w_pos       = (r_scan > LAST_POS) ? '0 : r_scan;
    assign w_digit     = r_digits[w_pos];
    assign w_seg       = {(POS_W'(r_point) == w_pos) && (r_point <= POINT_W'(LAST_POS)),
                          seg_pattern(w_digit)};
    assign w_sel       = ~(SEL_W'(1) << w_pos);
    assign w_next_scan = (w_pos >= LAST_POS) ? '0 : w_pos + POS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
            r_point <= POINT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                CFG_POINT: r_point <= i_cfg_data[POINT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_cmd <= i_in.cmd;
            r_p     <= PROD_W'(i_in.adc_code) * PROD_W'(r_scale);
        end
        if (w_v_free) begin
            r_v_cmd <= r_p_cmd;
            r_v     <= w_val;
        end
        if (w_v_go && (r_v_cmd == CMD_TICK)) begin
            r_o_seg <= w_seg;
            r_o_sel <= w_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_v_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_digits  <= '0;
            r_scan    <= '0;
        end else begin
            if (w_p_free) begin
                r_p_valid <= i_in.valid;
            end
            if (w_v_free) begin
                r_v_valid <= r_p_valid;
            end
            if (w_v_go && (r_v_cmd == CMD_TICK)) begin
                r_o_valid <= 1'b1;
                r_scan    <= w_next_scan;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            if (w_v_go && (r_v_cmd == CMD_SAMPLE)) begin
                r_digits <= w_split;
            end
        end
    end

    a_scan_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v_go && (r_v_cmd == CMD_TICK)) |=>
            (r_scan == (($past(r_scan) >= LAST_POS) ? '0 : $past(r_scan) + POS_W'(1))))
        else $error("scan position did not advance after a tick");

    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_valid |-> (r_v <= MAX_SHOWN))
        else $error("scaled value exceeds the displayable range");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_digits[0] <= DIGIT_W'(9)) && (r_digits[1] <= DIGIT_W'(9))
            && (r_digits[2] <= DIGIT_W'(9)))
        else $error("stored digit outside 0 to 9");

    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_out.ready && r_v_valid && (r_v_cmd == CMD_TICK) && r_p_valid)
            |-> !i_in.ready)
        else $error("input ready while the pipeline is full behind a stalled result");

endmodule
